### design/pfc_pkg.sv
// shared types and constants of the position frame checker
package pfc_pkg;

    // frame layout
    localparam logic [5:0]  FRAME_LEN   = 6'd43;
    localparam logic [5:0]  BODY_LAST   = 6'd40;
    localparam logic [5:0]  INDEX_MAX   = 6'd63;
    localparam logic [5:0]  HDR_ADDR    = 6'd0;
    localparam logic [5:0]  HDR_FUNC    = 6'd1;
    localparam logic [5:0]  HDR_LEN     = 6'd2;
    localparam logic [5:0]  COUNT_FIRST = 6'd11;
    localparam logic [5:0]  COUNT_LAST  = 6'd14;
    localparam logic [5:0]  RCRC_LO     = 6'd41;
    localparam logic [5:0]  RCRC_HI     = 6'd42;

    // expected header bytes
    localparam logic [7:0]  HDR_ADDR_VAL = 8'hFF;
    localparam logic [7:0]  HDR_FUNC_VAL = 8'h03;
    localparam logic [7:0]  HDR_LEN_VAL  = 8'h26;

    // modbus crc-16
    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;

    // scale for the percent result
    localparam logic [15:0] PCT_SCALE = 16'd100;

    // serial step counts, loaded as count minus one
    localparam logic [5:0]  CRC_STEPS = 6'd8;
    localparam logic [5:0]  MUL_STEPS = 6'd16;
    localparam logic [5:0]  DIV_STEPS = 6'd48;

    // register reset values
    localparam logic [31:0] COUNT_MIN_RST = 32'd0;
    localparam logic [31:0] COUNT_MAX_RST = 32'd65535;
    localparam logic [15:0] STROKE_RST    = 16'd1000;

    typedef enum logic [1:0] {
        CFG_COUNT_MIN = 2'd0,
        CFG_COUNT_MAX = 2'd1,
        CFG_STROKE    = 2'd2
    } cfg_index_t;

    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_BAD_LEN = 3'd1,
        ST_BAD_HDR = 3'd2,
        ST_BAD_CRC = 3'd3,
        ST_RANGE   = 3'd4
    } status_t;

endpackage

### design/position_frame_checker.sv
// position frame checker: modbus response check and position conversion
//
// channel   dir  handshake                    payload
// s_axis    in   s_axis_tvalid/s_axis_tready  tdata[7:0] rx_byte, tlast frame_end
// m_axis    out  m_axis_tvalid/m_axis_tready  tdata status, count, tenths, percent
// cfg       in   cfg_valid/cfg_ready          cfg_index, cfg_data
//
// a byte at frame index 0..40 is followed by 8 bit-serial crc steps before the next
// byte is taken, later bytes are taken without them; the final beat then starts one
// check, one range step and, for a good in-range frame, twice a shift-add multiply,
// a rounding add and a restoring divide on the single shared serial multiply/divide unit
// reset clears the registers to their defaults and the frame state to empty
// a result waits in the output register while the next frame's bytes come in;
// a second result holds the unit until the first beat is taken
module position_frame_checker
    import pfc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
    input  logic        s_axis_tlast,   // frame_end
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata,   // [2:0] status, [34:3] sensor_count,
                                        // [50:35] position_tenths_mm,
                                        // [57:51] position_percent, rest zero
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_CRC,
        S_CHECK,
        S_RANGE,
        S_MUL,
        S_ROUND,
        S_DIV,
        S_OUT
    } state_t;

    state_t      state_reg;

    // configuration
    logic [31:0] count_min_reg;
    logic [31:0] count_max_reg;
    logic [15:0] stroke_reg;

    // frame state
    logic [15:0] crc_reg;
    logic [5:0]  idx_reg;
    logic        hdr_good_reg;
    logic [15:0] rcv_crc_reg;
    logic [31:0] count_word_reg;
    logic        last_reg;

    // serial step counter and pass select (0 tenths, 1 percent)
    logic [5:0]  step_reg;
    logic        pass_reg;

    // result under construction
    status_t     res_status_reg;
    logic [31:0] res_count_reg;
    logic [15:0] res_tenths_reg;

    // output register
    logic        out_valid_reg;
    status_t     out_status_reg;
    logic [31:0] out_count_reg;
    logic [15:0] out_tenths_reg;
    logic [6:0]  out_pct_reg;

    // multiply/divide datapath, no reset needed
    logic [31:0] off_reg;
    logic [31:0] range_reg;
    logic [15:0] mplr_reg;
    logic [47:0] acc_reg;
    logic [47:0] num_reg;
    logic [31:0] rem_reg;
    logic [15:0] quo_reg;

    logic        in_beat;
    logic        out_free;
    logic        out_load;
    logic [15:0] crc_step;
    logic [31:0] count_shifted;
    logic        out_of_range;
    logic [47:0] acc_next;
    logic [32:0] trial;
    logic        quo_bit;
    logic [31:0] rem_next;
    logic [15:0] quo_next;

    assign s_axis_tready = (state_reg == S_IDLE);
    assign cfg_ready     = 1'b1;
    assign in_beat       = s_axis_tvalid && s_axis_tready;
    assign out_free      = !out_valid_reg || m_axis_tready;
    // a new result enters the output register this cycle
    assign out_load      = (state_reg == S_OUT) && out_free;

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {6'd0, out_pct_reg, out_tenths_reg, out_count_reg,
                            out_status_reg};

    always_comb
    begin
        // one bit of the reflected crc per cycle
        if (crc_reg[0])
            crc_step = (crc_reg >> 1) ^ CRC_POLY;
        else
            crc_step = crc_reg >> 1;

        // a count above count_max with a zero low byte is read as 1/256 units and drops that byte
        if (count_word_reg > count_max_reg && count_word_reg[7:0] == 8'd0)
            count_shifted = {8'd0, count_word_reg[31:8]};
        else
            count_shifted = count_word_reg;

        out_of_range = (res_count_reg < count_min_reg) || (res_count_reg > count_max_reg)
                       || (count_max_reg == count_min_reg);

        // shift-add multiply, multiplier msb first
        acc_next = {acc_reg[46:0], 1'b0} + (mplr_reg[15] ? {16'd0, off_reg} : 48'd0);

        // restoring divide, one quotient bit per cycle
        trial = {rem_reg, num_reg[47]};
        if (trial >= {1'b0, range_reg})
        begin
            quo_bit  = 1'b1;
            rem_next = 32'(trial - {1'b0, range_reg});
        end
        else
        begin
            quo_bit  = 1'b0;
            rem_next = trial[31:0];
        end
        quo_next = {quo_reg[14:0], quo_bit};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            count_min_reg  <= COUNT_MIN_RST;
            count_max_reg  <= COUNT_MAX_RST;
            stroke_reg     <= STROKE_RST;
            crc_reg        <= CRC_INIT;
            idx_reg        <= 6'd0;
            hdr_good_reg   <= 1'b1;
            rcv_crc_reg    <= 16'd0;
            count_word_reg <= 32'd0;
            last_reg       <= 1'b0;
            step_reg       <= 6'd0;
            pass_reg       <= 1'b0;
            res_status_reg <= ST_OK;
            res_count_reg  <= 32'd0;
            res_tenths_reg <= 16'd0;
            out_valid_reg  <= 1'b0;
            out_status_reg <= ST_OK;
            out_count_reg  <= 32'd0;
            out_tenths_reg <= 16'd0;
            out_pct_reg    <= 7'd0;
        end
        else
        begin
            if (cfg_valid)
            begin
                case (cfg_index)
                    CFG_COUNT_MIN: count_min_reg <= cfg_data;
                    CFG_COUNT_MAX: count_max_reg <= cfg_data;
                    CFG_STROKE:    stroke_reg    <= cfg_data[15:0];
                    default:       ;
                endcase
            end

            if (m_axis_tvalid && m_axis_tready && !out_load)
                out_valid_reg <= 1'b0;

            case (state_reg)
                S_IDLE:
                begin
                    if (in_beat)
                    begin
                        last_reg <= s_axis_tlast;
                        if ((idx_reg == HDR_ADDR && s_axis_tdata != HDR_ADDR_VAL) ||
                            (idx_reg == HDR_FUNC && s_axis_tdata != HDR_FUNC_VAL) ||
                            (idx_reg == HDR_LEN  && s_axis_tdata != HDR_LEN_VAL))
                            hdr_good_reg <= 1'b0;
                        if (idx_reg inside {[COUNT_FIRST:COUNT_LAST]})
                            count_word_reg <= {count_word_reg[23:0], s_axis_tdata};
                        if (idx_reg == RCRC_LO)
                            rcv_crc_reg[7:0] <= s_axis_tdata;
                        if (idx_reg == RCRC_HI)
                            rcv_crc_reg[15:8] <= s_axis_tdata;
                        if (idx_reg != INDEX_MAX)
                            idx_reg <= idx_reg + 6'd1;
                        if (idx_reg <= BODY_LAST)
                        begin
                            crc_reg   <= crc_reg ^ {8'd0, s_axis_tdata};
                            step_reg  <= CRC_STEPS - 6'd1;
                            state_reg <= S_CRC;
                        end
                        else if (s_axis_tlast)
                            state_reg <= S_CHECK;
                    end
                end

                S_CRC:
                begin
                    crc_reg  <= crc_step;
                    step_reg <= step_reg - 6'd1;
                    if (step_reg == 6'd0)
                        state_reg <= last_reg ? S_CHECK : S_IDLE;
                end

                S_CHECK:
                begin
                    // first failing check wins
                    res_tenths_reg <= 16'd0;
                    if (idx_reg != FRAME_LEN)
                    begin
                        res_status_reg <= ST_BAD_LEN;
                        res_count_reg  <= 32'd0;
                        state_reg      <= S_OUT;
                    end
                    else if (!hdr_good_reg)
                    begin
                        res_status_reg <= ST_BAD_HDR;
                        res_count_reg  <= 32'd0;
                        state_reg      <= S_OUT;
                    end
                    else if (crc_reg != rcv_crc_reg)
                    begin
                        res_status_reg <= ST_BAD_CRC;
                        res_count_reg  <= 32'd0;
                        state_reg      <= S_OUT;
                    end
                    else
                    begin
                        res_count_reg <= count_shifted;
                        state_reg     <= S_RANGE;
                    end
                end

                S_RANGE:
                begin
                    if (out_of_range)
                    begin
                        res_status_reg <= ST_RANGE;
                        state_reg      <= S_OUT;
                    end
                    else
                    begin
                        res_status_reg <= ST_OK;
                        pass_reg       <= 1'b0;
                        step_reg       <= MUL_STEPS - 6'd1;
                        state_reg      <= S_MUL;
                    end
                end

                S_MUL:
                begin
                    step_reg <= step_reg - 6'd1;
                    if (step_reg == 6'd0)
                        state_reg <= S_ROUND;
                end

                S_ROUND:
                begin
                    step_reg  <= DIV_STEPS - 6'd1;
                    state_reg <= S_DIV;
                end

                S_DIV:
                begin
                    step_reg <= step_reg - 6'd1;
                    if (step_reg == 6'd0)
                    begin
                        if (!pass_reg)
                        begin
                            res_tenths_reg <= quo_next;
                            pass_reg       <= 1'b1;
                            step_reg       <= MUL_STEPS - 6'd1;
                            state_reg      <= S_MUL;
                        end
                        else
                            state_reg <= S_OUT;
                    end
                end

                S_OUT:
                begin
                    if (out_free)
                    begin
                        out_valid_reg  <= 1'b1;
                        out_status_reg <= res_status_reg;
                        out_count_reg  <= res_count_reg;
                        out_tenths_reg <= res_tenths_reg;
                        // percent comes straight off the last divide
                        out_pct_reg    <= (res_status_reg == ST_OK) ? quo_reg[6:0] : 7'd0;
                        // frame state back to empty
                        crc_reg        <= CRC_INIT;
                        idx_reg        <= 6'd0;
                        hdr_good_reg   <= 1'b1;
                        rcv_crc_reg    <= 16'd0;
                        count_word_reg <= 32'd0;
                        last_reg       <= 1'b0;
                        state_reg      <= S_IDLE;
                    end
                end

                default: state_reg <= S_IDLE;
            endcase
        end
    end

    // serial multiply/divide unit
    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_RANGE:
            begin
                range_reg <= count_max_reg - count_min_reg;
                off_reg   <= res_count_reg - count_min_reg;
                mplr_reg  <= stroke_reg;
                acc_reg   <= 48'd0;
            end
            S_MUL:
            begin
                acc_reg  <= acc_next;
                mplr_reg <= {mplr_reg[14:0], 1'b0};
            end
            S_ROUND:
            begin
                // round half up by adding half the range
                num_reg <= acc_reg + {17'd0, range_reg[31:1]};
                rem_reg <= 32'd0;
                quo_reg <= 16'd0;
            end
            S_DIV:
            begin
                num_reg <= {num_reg[46:0], 1'b0};
                rem_reg <= rem_next;
                quo_reg <= quo_next;
                if (step_reg == 6'd0)
                begin
                    mplr_reg <= PCT_SCALE;
                    acc_reg  <= 48'd0;
                end
            end
            default: ;
        endcase
    end

    // a byte inside the crc body always holds off the next beat
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_beat && idx_reg <= BODY_LAST) |=> !s_axis_tready)
        else $error("byte accepted during crc steps");

    // a good frame never reports more than a full stroke in percent
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_status_reg == ST_OK) |-> (out_pct_reg <= 7'd100))
        else $error("percent above full stroke");

    // a failed frame reports no position
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_status_reg != ST_OK)
            |-> (out_tenths_reg == 16'd0 && out_pct_reg == 7'd0))
        else $error("position reported on failed frame");

endmodule

### dv/pfc_checker.sv
// frame result predictor and scoreboard for the position frame checker
module pfc_checker
    import pfc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,
    input  logic        s_axis_tlast,
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [63:0] m_axis_tdata,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data,
    output int          mismatches,
    output int          pending_frames,
    output int          frames_checked,
    output int          ok_results
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        status_t     status;
        logic [31:0] count;
        logic [15:0] tenths;
        logic [6:0]  percent;
    } frame_result_t;

    frame_result_t expected_frames [$];

    logic [31:0] lo_bound;
    logic [31:0] hi_bound;
    logic [15:0] stroke_len;

    logic [15:0] crc_acc;
    logic [5:0]  byte_idx;
    logic        hdr_ok;
    logic [15:0] body_crc;
    logic [15:0] rx_crc;
    logic [31:0] count_word;

    int bad;
    int checked;
    int ok_seen;

    function automatic logic [15:0] crc_fold(input logic [15:0] c, input logic [7:0] b);
        logic [15:0] r;
        r = c ^ {8'h00, b};
        for (int k = 0; k < 8; k++)
            r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
        return r;
    endfunction

    function automatic void clear_frame();
        crc_acc    = CRC_INIT;
        byte_idx   = '0;
        hdr_ok     = 1'b1;
        body_crc   = CRC_INIT;
        rx_crc     = '0;
        count_word = '0;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : track
        frame_result_t want;
        logic [5:0]    at;
        logic [31:0]   cnt;
        logic [31:0]   span;
        logic [31:0]   off;
        logic [63:0]   num;
        if (!rst_n)
        begin
            lo_bound   = COUNT_MIN_RST;
            hi_bound   = COUNT_MAX_RST;
            stroke_len = STROKE_RST;
            clear_frame();
            expected_frames.delete();
            bad     = 0;
            checked = 0;
            ok_seen = 0;
            mismatches     <= 0;
            pending_frames <= 0;
            frames_checked <= 0;
            ok_results     <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                case (cfg_index)
                    CFG_COUNT_MIN: lo_bound   = cfg_data;
                    CFG_COUNT_MAX: hi_bound   = cfg_data;
                    CFG_STROKE:    stroke_len = cfg_data[15:0];
                    default: ;
                endcase

            // results first: a result can never belong to a byte taken at the same edge
            if (m_axis_tvalid && m_axis_tready)
            begin
                checked++;
                if (expected_frames.size() == 0)
                begin
                    if (bad < 10)
                        $display("[%0t] result beat with no frame pending, tdata %h",
                                 $time, m_axis_tdata);
                    bad++;
                end
                else
                begin
                    want = expected_frames.pop_front();
                    if (m_axis_tdata[2:0] != want.status || m_axis_tdata[34:3] != want.count
                        || m_axis_tdata[50:35] != want.tenths
                        || m_axis_tdata[57:51] != want.percent || m_axis_tdata[63:58] != '0)
                    begin
                        if (bad < 10)
                            $display({"[%0t] result mismatch: expected status %0d count %0d ",
                                      "tenths %0d pct %0d, got status %0d count %0d tenths %0d ",
                                      "pct %0d pad %h"}, $time, want.status, want.count,
                                     want.tenths, want.percent, m_axis_tdata[2:0],
                                     m_axis_tdata[34:3], m_axis_tdata[50:35],
                                     m_axis_tdata[57:51], m_axis_tdata[63:58]);
                        bad++;
                    end
                    else if (want.status == ST_OK)
                        ok_seen++;
                end
            end

            if (s_axis_tvalid && s_axis_tready)
            begin
                at = byte_idx;
                if (at <= BODY_LAST)
                begin
                    crc_acc = crc_fold(crc_acc, s_axis_tdata);
                    if (at == BODY_LAST)
                        body_crc = crc_acc;
                end
                if ((at == HDR_ADDR && s_axis_tdata != HDR_ADDR_VAL)
                    || (at == HDR_FUNC && s_axis_tdata != HDR_FUNC_VAL)
                    || (at == HDR_LEN && s_axis_tdata != HDR_LEN_VAL))
                    hdr_ok = 1'b0;
                if (at >= COUNT_FIRST && at <= COUNT_LAST)
                    count_word = {count_word[23:0], s_axis_tdata};
                if (at == RCRC_LO)
                    rx_crc[7:0] = s_axis_tdata;
                if (at == RCRC_HI)
                    rx_crc[15:8] = s_axis_tdata;
                if (byte_idx != INDEX_MAX)
                    byte_idx = byte_idx + 6'd1;

                if (s_axis_tlast)
                begin
                    want = '0;
                    if (at != FRAME_LEN - 6'd1)
                        want.status = ST_BAD_LEN;
                    else if (!hdr_ok)
                        want.status = ST_BAD_HDR;
                    else if (body_crc != rx_crc)
                        want.status = ST_BAD_CRC;
                    else
                    begin
                        cnt = count_word;
                        // a count with an empty low byte above the range is read as shifted
                        if (cnt > hi_bound && cnt[7:0] == 8'h00)
                            cnt = cnt >> 8;
                        want.count = cnt;
                        if (cnt < lo_bound || cnt > hi_bound || hi_bound == lo_bound)
                            want.status = ST_RANGE;
                        else
                        begin
                            span = hi_bound - lo_bound;
                            off  = cnt - lo_bound;
                            num  = {32'd0, off} * {48'd0, stroke_len} + {33'd0, span[31:1]};
                            want.tenths  = 16'(num / {32'd0, span});
                            num  = {32'd0, off} * {48'd0, PCT_SCALE} + {33'd0, span[31:1]};
                            want.percent = 7'(num / {32'd0, span});
                            want.status  = ST_OK;
                        end
                    end
                    expected_frames.push_back(want);
                    clear_frame();
                end
            end

            mismatches     <= bad;
            pending_frames <= expected_frames.size();
            frames_checked <= checked;
            ok_results     <= ok_seen;
        end
    end

endmodule

### dv/testbench.sv
// testbench top: frame stimulus, register settings, back-pressure and verdict
module testbench;
    import pfc_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // run shape
    localparam int N_SETTINGS   = 9;      // register settings walked through
    localparam int SETTING_BEATS = 135;   // input beats per setting, about 1450 overall
    localparam int SETTING_FRAMES = 3;    // and at least this many closed frames each
    localparam int SETTLE_CYCLES = 200;   // longer than a final beat's conversion
    localparam int HOLD_CYCLES   = 3000;  // long receiver hold-off
    localparam int STALL_LIMIT   = 20000; // watchdog: cycles with no beat on any channel
    localparam int MAX_FRAME     = 70;    // longest frame sent, past index saturation

    // unused register slot, writes to it must be ignored
    localparam logic [1:0] CFG_SPARE = 2'd3;

    typedef enum logic [2:0] {
        FK_GOOD,
        FK_BAD_HDR,
        FK_BAD_CRC,
        FK_SHORT,
        FK_LONG,
        FK_NOISE
    } frame_kind_t;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;
    logic        s_axis_tlast;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [63:0] m_axis_tdata;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_index;
    logic [31:0] cfg_data;

    int mismatches;
    int pending_frames;
    int frames_checked;
    int ok_results;

    // stimulus bookkeeping
    logic [7:0]  frame_bytes [0:MAX_FRAME-1];
    logic [31:0] cfg_min;
    logic [31:0] cfg_max;
    logic [15:0] cfg_stroke;
    int          burst_left;
    int          beats_sent;
    int          frames_closed;

    position_frame_checker u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    // watches all three channels, predicts each frame result and compares
    pfc_checker u_chk (
        .clk            (clk),
        .rst_n          (rst_n),
        .s_axis_tvalid  (s_axis_tvalid),
        .s_axis_tready  (s_axis_tready),
        .s_axis_tdata   (s_axis_tdata),
        .s_axis_tlast   (s_axis_tlast),
        .m_axis_tvalid  (m_axis_tvalid),
        .m_axis_tready  (m_axis_tready),
        .m_axis_tdata   (m_axis_tdata),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .mismatches     (mismatches),
        .pending_frames (pending_frames),
        .frames_checked (frames_checked),
        .ok_results     (ok_results)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // crc used to seal generated frames, bytes 0..40
    function automatic logic [15:0] modbus_crc(input int upto);
        logic [15:0] c;
        c = CRC_INIT;
        for (int i = 0; i <= upto; i++)
        begin
            c = c ^ {8'h00, frame_bytes[i]};
            for (int k = 0; k < 8; k++)
                c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

    // sensor count aimed at the edges of the current range, plus the shifted form, zero, all ones and random counts
    function automatic logic [31:0] pick_count();
        logic [31:0] span;
        logic [31:0] x;
        span = cfg_max - cfg_min;
        x = (cfg_max > cfg_min) ? cfg_min + 32'($urandom_range(span, 0)) : $urandom;
        case ($urandom_range(0, 9))
            0:       return cfg_min;
            1:       return cfg_max;
            2:       return cfg_min - 32'd1;
            3:       return cfg_max + 32'd1;
            4:       return x << 8;
            5:       return 32'd0;
            6:       return 32'hFFFF_FFFF;
            7:       return $urandom;
            default: return x;
        endcase
    endfunction

    // well-formed frame: header, random body, big-endian count, random tail past the end
    task automatic fill_frame(input logic [31:0] count);
        for (int i = 0; i < MAX_FRAME; i++)
            frame_bytes[i] = 8'($urandom);
        frame_bytes[HDR_ADDR] = HDR_ADDR_VAL;
        frame_bytes[HDR_FUNC] = HDR_FUNC_VAL;
        frame_bytes[HDR_LEN]  = HDR_LEN_VAL;
        for (int i = 0; i < 4; i++)
            frame_bytes[COUNT_FIRST + i] = count[31 - 8*i -: 8];
    endtask

    task automatic seal_crc();
        logic [15:0] c;
        c = modbus_crc(BODY_LAST);
        frame_bytes[RCRC_LO] = c[7:0];
        frame_bytes[RCRC_HI] = c[15:8];
    endtask

    // one input beat; the sender may idle between bursts of random length
    task automatic send_byte(input logic [7:0] b, input logic last);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 14);
            if (gap != 0)
            begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = ($urandom_range(0, 5) == 0) ? 120 : $urandom_range(1, 30);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tlast  <= last;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        burst_left--;
        beats_sent++;
        if (last)
            frames_closed++;
    endtask

    task automatic send_frame(input int len);
        for (int i = 0; i < len; i++)
            send_byte(frame_bytes[i], i == len - 1);
    endtask

    // stop offering, let every pending result drain, then let the block settle
    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_frames != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // register beat; valid stays high across back-to-back writes
    task automatic cfg_beat(input logic [1:0] idx, input logic [31:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
    endtask

    task automatic apply_setting(input int n);
        case (n)
            1:
            begin
                cfg_min = 32'd0;        cfg_max = 32'hFFFF_FFFF; cfg_stroke = 16'hFFFF;
            end
            2:
            begin
                // zero range
                cfg_min = 32'd1000;     cfg_max = 32'd1000;      cfg_stroke = 16'd500;
            end
            3:
            begin
                // inverted range rejects every count
                cfg_min = 32'd5000;     cfg_max = 32'd100;       cfg_stroke = 16'd1000;
            end
            4:
            begin
                cfg_min = 32'hFFFF_FFFF; cfg_max = 32'hFFFF_FFFF; cfg_stroke = 16'd0;
            end
            5:
            begin
                cfg_min = 32'd0;        cfg_max = 32'd1;         cfg_stroke = 16'd0;
            end
            6:
            begin
                cfg_min = $urandom;
                cfg_max = cfg_min + 32'($urandom_range(1, 1000000));
                cfg_stroke = 16'($urandom);
            end
            7:
            begin
                cfg_min = $urandom_range(0, 1000);
                cfg_max = $urandom_range(2000, 70000);
                cfg_stroke = 16'($urandom);
            end
            default:
            begin
                cfg_min = COUNT_MIN_RST; cfg_max = COUNT_MAX_RST; cfg_stroke = STROKE_RST;
            end
        endcase
        if (n == 5)
            cfg_beat(CFG_SPARE, $urandom);
        cfg_beat(CFG_STROKE, {16'd0, cfg_stroke});
        cfg_beat(CFG_COUNT_MAX, cfg_max);
        cfg_beat(CFG_COUNT_MIN, cfg_min);
        if (n == 7)
            cfg_beat(CFG_SPARE, 32'hFFFF_FFFF);
        cfg_valid <= 1'b0;
    endtask

    task automatic send_kind(input frame_kind_t kind);
        int len;
        int pos;
        fill_frame(pick_count());
        case (kind)
            FK_GOOD:
            begin
                seal_crc();
                send_frame(FRAME_LEN);
            end
            FK_BAD_HDR:
            begin
                pos = $urandom_range(HDR_ADDR, HDR_LEN);
                frame_bytes[pos] = frame_bytes[pos] ^ (8'd1 << $urandom_range(0, 7));
                seal_crc();
                // sometimes the crc is wrong too, the header check must win
                if ($urandom_range(0, 1) == 1)
                    frame_bytes[RCRC_HI] = ~frame_bytes[RCRC_HI];
                send_frame(FRAME_LEN);
            end
            FK_BAD_CRC:
            begin
                seal_crc();
                pos = $urandom_range(HDR_LEN + 1, RCRC_HI);
                frame_bytes[pos] = frame_bytes[pos] ^ (8'd1 << $urandom_range(0, 7));
                send_frame(FRAME_LEN);
            end
            FK_SHORT:
            begin
                seal_crc();
                len = ($urandom_range(0, 2) == 0) ? FRAME_LEN - 1
                                                  : $urandom_range(1, FRAME_LEN - 1);
                send_frame(len);
            end
            FK_LONG:
            begin
                seal_crc();
                len = ($urandom_range(0, 2) == 0) ? FRAME_LEN + 1
                                                  : $urandom_range(FRAME_LEN + 1, MAX_FRAME);
                send_frame(len);
            end
            default:
            begin
                // loose bytes, the frame may stay open into the next one
                len = $urandom_range(1, 12);
                for (int i = 0; i < len; i++)
                    send_byte(8'($urandom), (i == len - 1) ? ($urandom_range(0, 1) == 1)
                                                            : ($urandom_range(0, 5) == 0));
            end
        endcase
    endtask

    // stimulus: short directed frames, then frame mixes under each register setting
    initial
    begin : stimulus
        frame_kind_t kind;
        int          roll;
        int          nth;
        int          beats_at_start;
        int          frames_at_start;
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tlast  = 1'b0;
        cfg_valid     = 1'b0;
        cfg_index     = CFG_COUNT_MIN;
        cfg_data      = '0;
        burst_left    = 0;
        beats_sent    = 0;
        frames_closed = 0;
        cfg_min       = COUNT_MIN_RST;
        cfg_max       = COUNT_MAX_RST;
        cfg_stroke    = STROKE_RST;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // directed: one-byte frames at both byte extremes, header alone, a two-byte frame
        send_byte(8'h00, 1'b1);
        send_byte(8'hFF, 1'b1);
        send_byte(HDR_ADDR_VAL, 1'b0);
        send_byte(HDR_FUNC_VAL, 1'b0);
        send_byte(HDR_LEN_VAL, 1'b1);
        send_byte(8'hAA, 1'b0);
        send_byte(8'h55, 1'b1);

        for (int n = 0; n < N_SETTINGS; n++)
        begin
            // register writes only once the block has gone quiet
            if (n != 0)
            begin
                wait_idle();
                apply_setting(n);
            end
            nth             = 0;
            beats_at_start  = beats_sent;
            frames_at_start = frames_closed;
            while (beats_sent - beats_at_start < SETTING_BEATS
                   || frames_closed - frames_at_start < SETTING_FRAMES)
            begin
                // each setting opens with its own frame kind, so every kind shows up,
                // then a weighted mix
                if (nth == 0)
                    kind = frame_kind_t'(n % 6);
                else
                begin
                    roll = $urandom_range(0, 99);
                    if (roll < 60)      kind = FK_GOOD;
                    else if (roll < 68) kind = FK_BAD_HDR;
                    else if (roll < 76) kind = FK_BAD_CRC;
                    else if (roll < 86) kind = FK_SHORT;
                    else if (roll < 93) kind = FK_LONG;
                    else                kind = FK_NOISE;
                end
                send_kind(kind);
                nth++;
            end
        end

        wait_idle();
        $display("run covered %0d input beats, %0d closed frames, %0d register settings",
                 beats_sent, frames_closed, N_SETTINGS);
        $display("%0d results compared, %0d of them in range with a position",
                 frames_checked, ok_results);
        if (mismatches == 0 && pending_frames == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    // receiver: alternating ready runs and stalls, one long hold-off mid-run
    initial
    begin : sink
        bit held;
        int run;
        held = 1'b0;
        m_axis_tready = 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (!held && frames_checked >= 12 && s_axis_tvalid)
            begin
                // the sender keeps going, so the block fills and stops taking bytes
                held = 1'b1;
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            run = ($urandom_range(0, 4) == 0) ? 200 : $urandom_range(1, 24);
            m_axis_tready <= 1'b1;
            repeat (run) @(posedge clk);
            run = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 40);
            if (run != 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (run) @(posedge clk);
            end
        end
    end

    // watchdog on cycles where no channel moves a beat
    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
                || (cfg_valid && cfg_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("watchdog: no beat for %0d cycles, %0d results pending",
                 STALL_LIMIT, pending_frames);
        $display("Some tests failed");
        $finish;
    end

endmodule

### sim.f
design/pfc_pkg.sv
design/position_frame_checker.sv
dv/pfc_checker.sv
dv/testbench.sv
